// ----- rtl/led_driver_packet_loader_assert.svh -----
// Assertion macros shared by the RTL. Each macro samples on clk and is
// disabled while arst_n is low.
`ifndef LED_DRIVER_PACKET_LOADER_ASSERT_SVH
`define LED_DRIVER_PACKET_LOADER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- rtl/ldpl_pkg.sv -----
`default_nettype none

package ldpl_pkg;

	// Event codes carried by the action field.
	typedef enum logic [1:0] {
		ACT_RX_BYTE   = 2'd0,
		ACT_SPI_READY = 2'd1,
		ACT_GS_TICK   = 2'd2
	} action_t;

	// Command nibble of an address byte.
	localparam logic [3:0] CMD_GRAYSCALE = 4'h0;
	localparam logic [3:0] CMD_DOT_CORR  = 4'h1;

	// Configuration register indexes.
	localparam logic REG_NODE_ADDRESS = 1'b0;
	localparam logic REG_GS_PERIOD    = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [3:0]  NODE_ADDRESS_RST = 4'd1;
	localparam logic [15:0] GS_PERIOD_RST    = 16'd4096;

	// Packet buffer geometry.
	localparam int unsigned STORE_DEPTH = 32;
	localparam int unsigned SLOT_W      = $clog2(STORE_DEPTH);

	// Status part of one result item.
	typedef struct packed {
		logic spi_valid;
		logic spi_last;
		logic vprg_level;
		logic xlat_pulse;
		logic blank_pulse;
		logic blank_level;
		logic receiver_awake;
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/led_driver_packet_loader.sv -----
`default_nettype none
// Packet loader and display-period controller for a serial grayscale LED driver.
// Items enter on the item channel (action, rx_byte, rx_is_address) with a
// valid/ready handshake. Action 0 delivers a received serial byte, action 1
// says the driver's serial port can take the next byte, action 2 is one
// grayscale clock tick. Every accepted item yields exactly one result item on
// the result channel, in order.
// Configuration (node address at index 0, grayscale period at index 1) is
// written through the cfg channel, which is always ready.
// Throughput is one item per clock unless the item channel stalls. A result
// passes the registered read of the packet buffer, then the output register.
// The output register and the buffer-read stage together let a new item enter
// while a finished result waits to be taken; the item channel stalls only
// when both stages are occupied and result_ready is low.
// Reset (arst_n low) clears all control state, restores the configuration
// defaults (node 1, period 4096) and clears the per-entry valid bits of the
// packet buffer, so every buffer entry reads as zero until it is written.
// No clearing pass is needed; the block is ready right after reset.
module led_driver_packet_loader
	import ldpl_pkg::*;
#(
	parameter int unsigned GS_LENGTH = 25,
	parameter int unsigned DC_LENGTH = 13
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,

	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        rx_is_address,

	output logic             result_valid,
	input  wire logic        result_ready,
	output logic             spi_valid,
	output logic [7:0]       spi_byte,
	output logic             spi_last,
	output logic             vprg_level,
	output logic             xlat_pulse,
	output logic             blank_pulse,
	output logic             blank_level,
	output logic             receiver_awake
);

	// Packet lengths in slots; the user must keep a packet to at most STORE_DEPTH slots, which the block does not enforce.
	localparam logic [SLOT_W:0] GS_LEN = (SLOT_W + 1)'(GS_LENGTH);
	localparam logic [SLOT_W:0] DC_LEN = (SLOT_W + 1)'(DC_LENGTH);
	localparam logic [SLOT_W-1:0] FIRST_SLOT = SLOT_W'(1);

	// Configuration registers.
	logic [3:0]  node_address_q;
	logic [15:0] gs_period_q;

	// Control state.
	logic [SLOT_W-1:0] slot_q, slot_n;
	logic gs_mode_q, gs_mode_n;
	logic init_done_q, init_done_n;
	logic latch_pending_q, latch_pending_n;
	logic awake_q, awake_n;
	logic shifting_q, shifting_n;
	logic [15:0] tick_q, tick_n;

	// Packet buffer and its per-entry valid bits.
	logic [7:0] store_mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] store_vld_q;
	logic wr_en;
	logic [SLOT_W-1:0] rd_addr;

	// Buffer-read stage and output register.
	logic       valid_s1;
	status_t    status_s1;
	logic [7:0] rd_data_s1;
	logic       rd_vld_s1;
	status_t    status_n;
	status_t    out_status_q;
	logic [7:0] out_byte_q;
	logic       out_valid_q;

	logic fire;
	logic s1_adv;
	logic [SLOT_W:0] pkt_len;
	logic [SLOT_W:0] slot_inc;
	logic pkt_end;
	logic short_pkt;
	logic [16:0] tick_inc;
	logic period_end;
	logic pkt_done;

	assign cfg_ready  = 1'b1;
	assign s1_adv     = !out_valid_q || result_ready;
	assign item_ready = !valid_s1 || s1_adv;
	assign fire       = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_address_q <= NODE_ADDRESS_RST;
			gs_period_q    <= GS_PERIOD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NODE_ADDRESS: node_address_q <= cfg_data[3:0];
				REG_GS_PERIOD:    gs_period_q    <= cfg_data;
				default:          ;
			endcase
		end
	end

	assign pkt_len    = gs_mode_q ? GS_LEN : DC_LEN;
	assign slot_inc   = {1'b0, slot_q} + (SLOT_W + 1)'(1);
	assign pkt_end    = slot_inc >= pkt_len;
	assign short_pkt  = pkt_len <= (SLOT_W + 1)'(1);
	assign tick_inc   = {1'b0, tick_q} + 17'd1;
	assign period_end = tick_inc >= {1'b0, gs_period_q};

	// Next state for one accepted item.
	always_comb begin
		slot_n          = slot_q;
		gs_mode_n       = gs_mode_q;
		init_done_n     = init_done_q;
		latch_pending_n = latch_pending_q;
		awake_n         = awake_q;
		shifting_n      = shifting_q;
		tick_n          = tick_q;
		wr_en           = 1'b0;
		rd_addr         = '0;
		pkt_done        = 1'b0;
		status_n        = '0;
		if (fire) begin
			unique case (action)
				ACT_RX_BYTE: begin
					if (rx_is_address) begin
						awake_n = 1'b0;
						if (rx_byte[3:0] == node_address_q) begin
							if (rx_byte[7:4] == CMD_GRAYSCALE) begin
								gs_mode_n   = 1'b1;
								awake_n     = 1'b1;
								init_done_n = 1'b1;
							end else if (rx_byte[7:4] == CMD_DOT_CORR) begin
								gs_mode_n = 1'b0;
								awake_n   = 1'b1;
							end
						end
					end else if (awake_q && !shifting_q) begin
						wr_en = 1'b1;
						if (pkt_end) begin
							// Packet complete: start the transfer with slot zero.
							awake_n            = 1'b0;
							status_n.spi_valid = 1'b1;
							slot_n             = FIRST_SLOT;
							if (short_pkt) begin
								status_n.spi_last = 1'b1;
								latch_pending_n   = 1'b1;
							end else begin
								shifting_n = 1'b1;
							end
						end else begin
							slot_n = slot_inc[SLOT_W-1:0];
						end
					end
				end
				ACT_SPI_READY: begin
					if (shifting_q) begin
						status_n.spi_valid = 1'b1;
						rd_addr            = slot_q;
						if (pkt_end) begin
							slot_n            = FIRST_SLOT;
							latch_pending_n   = 1'b1;
							shifting_n        = 1'b0;
							status_n.spi_last = 1'b1;
							pkt_done          = 1'b1;
						end else begin
							slot_n = slot_inc[SLOT_W-1:0];
						end
					end
				end
				ACT_GS_TICK: begin
					if (period_end) begin
						tick_n               = '0;
						status_n.blank_pulse = 1'b1;
						if (latch_pending_q) begin
							status_n.xlat_pulse = 1'b1;
							latch_pending_n     = 1'b0;
						end
					end else begin
						tick_n = tick_inc[15:0];
					end
				end
				default: ;
			endcase
		end
		status_n.vprg_level     = !gs_mode_n;
		status_n.blank_level    = !init_done_n;
		status_n.receiver_awake = awake_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q          <= FIRST_SLOT;
			gs_mode_q       <= 1'b0;
			init_done_q     <= 1'b0;
			latch_pending_q <= 1'b0;
			awake_q         <= 1'b0;
			shifting_q      <= 1'b0;
			tick_q          <= '0;
		end else begin
			slot_q          <= slot_n;
			gs_mode_q       <= gs_mode_n;
			init_done_q     <= init_done_n;
			latch_pending_q <= latch_pending_n;
			awake_q         <= awake_n;
			shifting_q      <= shifting_n;
			tick_q          <= tick_n;
		end
	end

	// A buffer write and a read of the same entry never meet in one cycle:
	// writes happen only while no transfer runs, and reads of written slots only
	// during one, so a read always sees the array after every earlier write has landed.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[slot_q] <= rx_byte;
		end
		if (fire) begin
			rd_data_s1 <= store_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_vld_q <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			if (wr_en) begin
				store_vld_q[slot_q] <= 1'b1;
			end
			if (fire) begin
				rd_vld_s1 <= store_vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s1 <= status_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			out_status_q <= status_s1;
			out_byte_q   <= (status_s1.spi_valid && rd_vld_s1) ? rd_data_s1 : 8'h00;
		end
	end

	assign result_valid   = out_valid_q;
	assign spi_valid      = out_status_q.spi_valid;
	assign spi_byte       = out_byte_q;
	assign spi_last       = out_status_q.spi_last;
	assign vprg_level     = out_status_q.vprg_level;
	assign xlat_pulse     = out_status_q.xlat_pulse;
	assign blank_pulse    = out_status_q.blank_pulse;
	assign blank_level    = out_status_q.blank_level;
	assign receiver_awake = out_status_q.receiver_awake;

`include "led_driver_packet_loader_assert.svh"

	`ASSERT_SAME(a_slot_nonzero, 1'b1, slot_q != '0)
	`ASSERT_SAME(a_last_has_byte, result_valid && spi_last, spi_valid)
	`ASSERT_SAME(a_xlat_on_blank, result_valid && xlat_pulse, blank_pulse)
	`ASSERT_NEXT(a_transfer_end_latches, pkt_done, latch_pending_q && !shifting_q)
	`ASSERT_SAME(a_full_stalls, valid_s1 && out_valid_q && !result_ready, !item_ready)

endmodule

`default_nettype wire

// ----- tb/tb_led_driver_packet_loader.sv -----
`timescale 1ns / 100ps

module tb_led_driver_packet_loader;
	import ldpl_pkg::*;

	// Packet lengths in bytes, address slot included, as the block is built here.
	localparam int unsigned GS_LEN = 25;
	localparam int unsigned DC_LEN = 13;

	// The action field is two bits wide, so the fourth code can be sent too.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// Run control. The cycle limit sits far above the slowest legal run.
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int CHOKE_AT      = 500;
	localparam int CHOKE_CYCLES  = 300;
	localparam int PHASES        = 7;
	localparam int PHASE_ITEMS   = 170;
	localparam int SETTLE_CYCLES = 6;

	// One input item as the driver presents it.
	typedef struct packed {
		logic [1:0] act;
		logic [7:0] data;
		logic       is_addr;
	} rx_event_t;

	// One result item, field by field.
	typedef struct packed {
		logic       spi_valid;
		logic [7:0] spi_byte;
		logic       spi_last;
		logic       vprg;
		logic       xlat;
		logic       blank;
		logic       blank_lvl;
		logic       awake;
	} loader_out_t;

	// Every input of the block starts at a known value.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = 16'd0;
	logic        item_valid = 1'b0;
	logic [1:0]  action = ACT_UNUSED;
	logic [7:0]  rx_byte = 8'd0;
	logic        rx_is_address = 1'b0;
	logic        result_ready = 1'b0;

	logic        cfg_ready;
	logic        item_ready;
	logic        result_valid;
	logic        spi_valid;
	logic [7:0]  spi_byte;
	logic        spi_last;
	logic        vprg_level;
	logic        xlat_pulse;
	logic        blank_pulse;
	logic        blank_level;
	logic        receiver_awake;

	led_driver_packet_loader #(
		.GS_LENGTH(GS_LEN),
		.DC_LENGTH(DC_LEN)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.action        (action),
		.rx_byte       (rx_byte),
		.rx_is_address (rx_is_address),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.spi_valid     (spi_valid),
		.spi_byte      (spi_byte),
		.spi_last      (spi_last),
		.vprg_level    (vprg_level),
		.xlat_pulse    (xlat_pulse),
		.blank_pulse   (blank_pulse),
		.blank_level   (blank_level),
		.receiver_awake(receiver_awake)
	);

	// 10 ns clock: five high, five low.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Items waiting to be offered, and results the loader owes us, oldest first.
	rx_event_t   pending_events[$];
	loader_out_t due_outputs[$];

	// Our own copy of the loader: packet buffer, receive/shift pointer, mode flags,
	// grayscale tick counter and the two configuration registers.
	logic [7:0]        pkt_buf [STORE_DEPTH];
	logic [SLOT_W-1:0] slot;
	logic              gs_mode;
	logic              init_seen;
	logic              latch_due;
	logic              rx_awake;
	logic              shifting_out;
	logic [16:0]       tick_cnt;
	logic [3:0]        node_sel;
	logic [15:0]       gs_len;

	int  cycle_count = 0;
	int  items_accepted = 0;
	int  result_count = 0;
	int  mismatches = 0;
	logic item_taken = 1'b0;
	int  send_pause = 0;
	int  send_calm = 0;
	int  take_pause = 0;
	int  take_calm = 0;
	int  choke_left = 0;
	bit  choke_done = 1'b0;

	task automatic clear_loader();
		foreach (pkt_buf[i])
			pkt_buf[i] = 8'h00;
		slot = SLOT_W'(1);
		gs_mode = 1'b0;
		init_seen = 1'b0;
		latch_due = 1'b0;
		rx_awake = 1'b0;
		shifting_out = 1'b0;
		tick_cnt = '0;
		node_sel = NODE_ADDRESS_RST;
		gs_len = GS_PERIOD_RST;
	endtask

	function automatic int unsigned packet_len();
		return gs_mode ? GS_LEN : DC_LEN;
	endfunction

	// Applies one item to our copy of the loader and returns the result it causes.
	function automatic loader_out_t loader_step(logic [1:0] act, logic [7:0] data,
			logic is_addr);
		loader_out_t res;
		logic [SLOT_W:0] nxt;
		res = '0;
		case (act)
			ACT_RX_BYTE: begin
				if (is_addr) begin
					// Any address byte drops the receiver first; only our node with a
					// known command wakes it again. The slot pointer is left alone, so
					// an interrupted packet picks up where it stopped.
					rx_awake = 1'b0;
					if (data[3:0] == node_sel) begin
						if (data[7:4] == CMD_GRAYSCALE) begin
							gs_mode = 1'b1;
							rx_awake = 1'b1;
							init_seen = 1'b1;
						end else if (data[7:4] == CMD_DOT_CORR) begin
							gs_mode = 1'b0;
							rx_awake = 1'b1;
						end
					end
				end else if (rx_awake && !shifting_out) begin
					pkt_buf[slot] = data;
					nxt = {1'b0, slot} + 1'b1;
					if (nxt >= packet_len()) begin
						// Packet complete: slot 0 goes out at once, the rest on SPI ready.
						rx_awake = 1'b0;
						res.spi_valid = 1'b1;
						res.spi_byte = pkt_buf[0];
						slot = SLOT_W'(1);
						if (packet_len() <= 1) begin
							res.spi_last = 1'b1;
							latch_due = 1'b1;
						end else begin
							shifting_out = 1'b1;
						end
					end else begin
						slot = nxt[SLOT_W-1:0];
					end
				end
			end
			ACT_SPI_READY: begin
				if (shifting_out) begin
					res.spi_valid = 1'b1;
					res.spi_byte = pkt_buf[slot];
					nxt = {1'b0, slot} + 1'b1;
					if (nxt >= packet_len()) begin
						slot = SLOT_W'(1);
						latch_due = 1'b1;
						shifting_out = 1'b0;
						res.spi_last = 1'b1;
					end else begin
						slot = nxt[SLOT_W-1:0];
					end
				end
			end
			ACT_GS_TICK: begin
				// A period of zero acts like one: every tick ends a period.
				tick_cnt = tick_cnt + 1'b1;
				if (tick_cnt >= gs_len) begin
					tick_cnt = '0;
					res.blank = 1'b1;
					if (latch_due) begin
						res.xlat = 1'b1;
						latch_due = 1'b0;
					end
				end
			end
			default: ;
		endcase
		res.vprg = !gs_mode;
		res.blank_lvl = !init_seen;
		res.awake = rx_awake;
		return res;
	endfunction

	// Pause length for either side: mostly none or short, now and then long, and
	// once in a while a calm stretch with no pauses at all.
	function automatic int pick_pause(inout int calm_left);
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 199);
		if (r < 2) begin
			calm_left = $urandom_range(30, 150);
			return 0;
		end
		if (r < 110)
			return 0;
		if (r < 170)
			return $urandom_range(1, 3);
		if (r < 194)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 40)
			$display("result %0d: %s is %0h, expected %0h", result_count, what, got, want);
	endtask

	// Sender. A new item goes up only once the previous one was taken at the last
	// rising edge (or nothing was offered), so valid and payload hold steady while
	// the loader stalls.
	always @(negedge clk) begin : drive_items
		rx_event_t ev;
		if (arst_n && (!item_valid || item_taken)) begin
			if (send_pause > 0) begin
				send_pause--;
				item_valid <= 1'b0;
			end else if (pending_events.size() != 0) begin
				ev = pending_events.pop_front();
				action <= ev.act;
				rx_byte <= ev.data;
				rx_is_address <= ev.is_addr;
				item_valid <= 1'b1;
				send_pause = pick_pause(send_calm);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver. Random stalls, plus one long hold-off once enough items have gone
	// in, so the loader's two result stages fill and item_ready drops while the
	// sender keeps offering.
	always @(negedge clk) begin : take_results
		if (choke_left > 0) begin
			choke_left--;
			result_ready <= 1'b0;
		end else if (!choke_done && items_accepted >= CHOKE_AT) begin
			choke_done = 1'b1;
			choke_left = CHOKE_CYCLES;
			result_ready <= 1'b0;
		end else if (take_pause > 0) begin
			take_pause--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
			take_pause = pick_pause(take_calm);
		end
	end

	// Watcher on the rising edge: accepted items feed our copy of the loader,
	// accepted results are checked against the oldest owed result.
	always @(posedge clk) begin : watch_ports
		loader_out_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			item_taken <= arst_n && item_valid && item_ready;
			if (arst_n && item_valid && item_ready) begin
				due_outputs.push_back(loader_step(action, rx_byte, rx_is_address));
				items_accepted++;
			end
			if (arst_n && result_valid && result_ready) begin
				result_count++;
				if (due_outputs.size() == 0) begin
					flag_mismatch("unexpected result, valid", 1, 0);
				end else begin
					want = due_outputs.pop_front();
					if (spi_valid !== want.spi_valid)
						flag_mismatch("spi_valid", spi_valid, want.spi_valid);
					if (spi_byte !== want.spi_byte)
						flag_mismatch("spi_byte", spi_byte, want.spi_byte);
					if (spi_last !== want.spi_last)
						flag_mismatch("spi_last", spi_last, want.spi_last);
					if (vprg_level !== want.vprg)
						flag_mismatch("vprg_level", vprg_level, want.vprg);
					if (xlat_pulse !== want.xlat)
						flag_mismatch("xlat_pulse", xlat_pulse, want.xlat);
					if (blank_pulse !== want.blank)
						flag_mismatch("blank_pulse", blank_pulse, want.blank);
					if (blank_level !== want.blank_lvl)
						flag_mismatch("blank_level", blank_level, want.blank_lvl);
					if (receiver_awake !== want.awake)
						flag_mismatch("receiver_awake", receiver_awake, want.awake);
				end
			end
		end
	end

	task automatic push_event(input logic [1:0] act, input logic [7:0] data,
			input logic is_addr);
		rx_event_t ev;
		ev.act = act;
		ev.data = data;
		ev.is_addr = is_addr;
		pending_events.push_back(ev);
	endtask

	function automatic logic [7:0] rand_byte();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return $urandom_range(0, 255);
	endfunction

	// Checked on the rising edge: an item taken at this edge still shows valid
	// high here, so nothing in flight is missed.
	task automatic wait_quiet(input int settle);
		do
			@(posedge clk);
		while (pending_events.size() != 0 || item_valid || due_outputs.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	// Register write on the config channel; our copy follows at the same edge.
	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_NODE_ADDRESS)
			node_sel = val[3:0];
		else
			gs_len = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One stretch of random traffic. Most of it is well-formed packets addressed
	// to this node, with ticks, stray bytes and mode switches mixed in; the rest
	// is cut-off packets, foreign or bad addresses, and plain noise.
	task automatic add_sequence();
		int r;
		int n;
		int cut;
		logic [3:0] cmd;
		logic [3:0] other_cmd;
		r = $urandom_range(0, 99);
		cmd = $urandom_range(0, 1) ? CMD_GRAYSCALE : CMD_DOT_CORR;
		other_cmd = (cmd == CMD_GRAYSCALE) ? CMD_DOT_CORR : CMD_GRAYSCALE;
		n = ((cmd == CMD_GRAYSCALE) ? GS_LEN : DC_LEN) - 1;
		if (r < 65) begin
			push_event(ACT_RX_BYTE, {cmd, node_sel}, 1'b1);
			repeat (n) begin
				if ($urandom_range(0, 9) == 0)
					push_event(ACT_GS_TICK, rand_byte(), 1'b0);
				push_event(ACT_RX_BYTE, rand_byte(), 1'b0);
			end
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 8)
					push_event(ACT_GS_TICK, rand_byte(), 1'b0);
				else if (r < 12)
					push_event(ACT_RX_BYTE, rand_byte(), 1'b0);
				else if (r < 15)
					push_event(ACT_RX_BYTE, {other_cmd, node_sel}, 1'b1);
				push_event(ACT_SPI_READY, rand_byte(), 1'b0);
			end
			repeat ($urandom_range(0, 5))
				push_event(ACT_GS_TICK, rand_byte(), 1'b0);
		end else if (r < 85) begin
			cut = $urandom_range(0, n - 1);
			push_event(ACT_RX_BYTE, {cmd, node_sel}, 1'b1);
			repeat (cut)
				push_event(ACT_RX_BYTE, rand_byte(), 1'b0);
			case ($urandom_range(0, 2))
				0: push_event(ACT_RX_BYTE,
					{4'($urandom_range(0, 15)), 4'(node_sel + $urandom_range(1, 15))}, 1'b1);
				1: push_event(ACT_RX_BYTE, {4'($urandom_range(2, 15)), node_sel}, 1'b1);
				default: push_event(ACT_RX_BYTE, {other_cmd, node_sel}, 1'b1);
			endcase
		end else begin
			repeat ($urandom_range(1, 8))
				push_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
		end
	endtask

	logic [3:0]  node_plan [PHASES] = '{4'd0, 4'd15, 4'd7, 4'd15, 4'd3, 4'd0, 4'd9};
	logic [15:0] period_plan [PHASES] = '{16'd1, 16'd0, 16'd3, 16'd65535, 16'd17,
		16'd5, 16'd2};

	initial begin
		clear_loader();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, node at its reset value 1 and a two-tick period so the
		// blank and latch show up quickly.
		write_reg(REG_GS_PERIOD, 16'd2);
		push_event(ACT_RX_BYTE, 8'hFF, 1'b0);             // data byte while dormant
		push_event(ACT_SPI_READY, 8'h00, 1'b0);           // SPI ready with nothing to send
		push_event(ACT_UNUSED, 8'hA5, 1'b1);              // unused action code
		push_event(ACT_RX_BYTE, 8'hF0, 1'b1);             // another node's address
		push_event(ACT_RX_BYTE, 8'h21, 1'b1);             // our node, unknown command
		push_event(ACT_RX_BYTE, {CMD_DOT_CORR, 4'd1}, 1'b1);
		push_event(ACT_RX_BYTE, 8'h00, 1'b0);
		push_event(ACT_RX_BYTE, 8'hFF, 1'b0);
		for (int i = 0; i < DC_LEN - 3; i++)
			push_event(ACT_RX_BYTE, 8'(8'h11 * i + 8'h5A), 1'b0);
		repeat (DC_LEN - 1)
			push_event(ACT_SPI_READY, 8'h00, 1'b0);
		push_event(ACT_GS_TICK, 8'h00, 1'b0);
		push_event(ACT_GS_TICK, 8'h00, 1'b0);             // period end with a latch due
		wait_quiet(SETTLE_CYCLES);

		// Random phases, each under its own node number and period.
		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_NODE_ADDRESS, {12'd0, node_plan[p]});
			write_reg(REG_GS_PERIOD, period_plan[p]);
			while (pending_events.size() < PHASE_ITEMS)
				add_sequence();
			wait_quiet(SETTLE_CYCLES);
		end

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
